[rtl/chip_temperature_median_calc_defines.svh]
// Assertion macros shared by the chip temperature median block.
`ifndef CHIP_TEMPERATURE_MEDIAN_CALC_DEFINES_SVH
`define CHIP_TEMPERATURE_MEDIAN_CALC_DEFINES_SVH
`ifndef SYNTHESIS
`define CTM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define CTM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) ante |=> cons) else $error(msg);
`else
`define CTM_ASSERT(label, prop, msg)
`define CTM_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[rtl/ctm_pkg.sv]
`timescale 1ns / 1ps
// Package with the constants, types and helper functions of the chip temperature median block.
package ctm_pkg;

   localparam int RAW_W      = 12;
   localparam int CAL_W      = 12;
   localparam int OFFSET_W   = 8;
   localparam int TEMP_W     = 24;
   localparam int MV_W       = 24;
   localparam int STATUS_W   = 2;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam int DIV_W      = 36;
   localparam int DIVISOR_W  = 12;
   localparam int DIV_DIGITS = DIV_W / 2;
   localparam int DIV_CNT_W  = $clog2(DIV_DIGITS);
   localparam int MUL_DIGITS = RAW_W / 2;
   localparam int MUL_CNT_W  = $clog2(MUL_DIGITS);
   localparam int RAW3_W     = 25;
   localparam int SUM_W      = DIV_W + 2;

   localparam int VREF_CAL_MV   = 3600;
   localparam int SENSOR_CAL_MV = 3000;
   localparam int CAL_LOW_TEMP  = 30;
   localparam int CAL_HIGH_TEMP = 130;
   localparam int TENTHS        = 10;
   localparam int TEMP_BASE     = CAL_LOW_TEMP * TENTHS;
   localparam int TEMP_SPAN     = (CAL_HIGH_TEMP - CAL_LOW_TEMP) * TENTHS;
   localparam int T24_MAX       = 8388607;
   localparam int T24_MIN       = -8388608;

   localparam int VREF_CAL_RESET   = 1378;
   localparam int CAL_LOW_RESET    = 1040;
   localparam int CAL_HIGH_RESET   = 1380;
   localparam int TEMP_OFFSET_RESET = 0;

   typedef enum logic [1:0] {
      CSR_VREF_CAL,
      CSR_CAL_LOW,
      CSR_CAL_HIGH,
      CSR_TEMP_OFFSET
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 0,
      STATUS_ZERO_REF  = 1,
      STATUS_EQUAL_CAL = 2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_VDDA,
      ST_MUL,
      ST_DIV_RAW3,
      ST_SCALE,
      ST_DIV_TEMP,
      ST_TEMP,
      ST_MEDIAN,
      ST_EMIT
   } ctm_state_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic signed [TEMP_W-1:0] sat_temp(input logic signed [SUM_W-1:0] x);
      logic signed [TEMP_W-1:0] r;
      if (x > $signed(SUM_W'(T24_MAX))) begin
         r = TEMP_W'(T24_MAX);
      end else if (x < $signed(SUM_W'(T24_MIN))) begin
         r = TEMP_W'(T24_MIN);
      end else begin
         r = x[TEMP_W-1:0];
      end
      return r;
   endfunction

endpackage

[rtl/ctm_req_if.sv]
`timescale 1ns / 1ps
// Interface of the measurement input channel.
interface ctm_req_if import ctm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [RAW_W-1:0] vref_code;
   logic [RAW_W-1:0] raw_sensor;

   modport source (output valid, output vref_code, output raw_sensor, input ready);
   modport sink (input valid, input vref_code, input raw_sensor, output ready);
endinterface

[rtl/ctm_rsp_if.sv]
`timescale 1ns / 1ps
// Interface of the temperature result channel.
interface ctm_rsp_if import ctm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temp_tenths;
   logic [MV_W-1:0]          supply_mv;
   logic [STATUS_W-1:0]      status;

   modport source (output valid, output temp_tenths, output supply_mv, output status,
                   input ready);
   modport sink (input valid, input temp_tenths, input supply_mv, input status,
                 output ready);
endinterface

[rtl/ctm_div.sv]
`timescale 1ns / 1ps
// Radix-4 restoring divider that retires two quotient bits per cycle.
`include "chip_temperature_median_calc_defines.svh"
module ctm_div import ctm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [DIVISOR_W-1:0] divisor_ff, divisor_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;

   logic [DIVISOR_W:0]   part1, part2, trial1, trial2;
   logic                 ge1, ge2;
   logic [DIVISOR_W-1:0] rem1, rem2;

   always_comb begin
      part1  = {rem_ff, quo_ff[DIV_W-1]};
      trial1 = part1 - {1'b0, divisor_ff};
      ge1    = part1 >= {1'b0, divisor_ff};
      rem1   = ge1 ? trial1[DIVISOR_W-1:0] : part1[DIVISOR_W-1:0];
      part2  = {rem1, quo_ff[DIV_W-2]};
      trial2 = part2 - {1'b0, divisor_ff};
      ge2    = part2 >= {1'b0, divisor_ff};
      rem2   = ge2 ? trial2[DIVISOR_W-1:0] : part2[DIVISOR_W-1:0];

      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;

      if (div_req.start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         divisor_in = div_req.divisor;
         rem_in     = '0;
         quo_in     = div_req.dividend;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[DIV_W-3:0], ge1, ge2};
         rem_in   = rem2;
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_CNT_W'(DIV_DIGITS - 1)) begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   `CTM_ASSERT(div_start_when_free, div_req.start |-> !busy_ff, "divider started while busy")
   `CTM_ASSERT_NEXT(div_start_loads, div_req.start, busy_ff && count_ff == '0, "divider did not start")
   `CTM_ASSERT(div_count_idle, count_ff != '0 |-> busy_ff, "divider count moved while idle")

endmodule

[rtl/chip_temperature_median_calc.sv]
`timescale 1ns / 1ps
// Top level: calibrated chip temperature, median of three measurements.
//
//   channel   direction  handshake              beat
//   req_ch    in         valid/ready            vref_code, raw_sensor
//   rsp_ch    out        valid/ready            temp_tenths, supply_mv, status
//   csr_*     in         APB write, pready = 1  four calibration registers
//
// A measurement passes three times through the shared radix-4 divider and once through a
// serial multiply; the third of a group also takes the median before its result is emitted.
// A zero reference code or equal calibration codes skips the arithmetic and goes straight to
// the emit state, which loads the output register once it is free and then frees the input.
// Reset is synchronous and empties the group and the output register.
// A new beat is taken while a result waits; the next result stalls until the register is free.
`include "chip_temperature_median_calc_defines.svh"
module chip_temperature_median_calc import ctm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ctm_req_if.sink               req_ch,
   ctm_rsp_if.source             rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   ctm_state_type state_ff, state_in;

   logic [CAL_W-1:0]           vref_cal_ff, vref_cal_in;
   logic [CAL_W-1:0]           cal_low_ff, cal_low_in;
   logic [CAL_W-1:0]           cal_high_ff, cal_high_in;
   logic signed [OFFSET_W-1:0] offset_ff, offset_in;

   logic [1:0]                 group_count_ff, group_count_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [MUL_CNT_W-1:0]       mul_count_ff, mul_count_in;

   status_type                 status_ff, status_in;
   logic [RAW_W-1:0]           sensor_ff, sensor_in;
   logic [DIV_W-1:0]           acc_ff, acc_in;
   logic [MV_W-1:0]            vdda_ff, vdda_in;
   logic [RAW3_W-1:0]          mag_ff, mag_in;
   logic                       neg_ff, neg_in;
   logic signed [TEMP_W-1:0]   t_ff, t_in;
   logic signed [TEMP_W-1:0]   med_t_ff, med_t_in;
   logic [MV_W-1:0]            med_v_ff, med_v_in;
   logic signed [TEMP_W-1:0]   held_t_ff [2];
   logic signed [TEMP_W-1:0]   held_t_in [2];
   logic [MV_W-1:0]            held_v_ff [2];
   logic [MV_W-1:0]            held_v_in [2];
   logic signed [TEMP_W-1:0]   rsp_temp_ff, rsp_temp_in;
   logic [MV_W-1:0]            rsp_supply_ff, rsp_supply_in;
   status_type                 rsp_status_ff, rsp_status_in;

   div_req_type                div_req;
   div_rsp_type                div_rsp;

   logic                       req_ready;
   logic                       req_fire;
   logic                       csr_write;
   csr_index_type              csr_index;

   logic [MV_W-1:0]            vref_scaled;
   logic [MV_W+1:0]            digit_prod;
   logic [DIV_W-1:0]           mul_sum;
   logic [RAW3_W-1:0]          raw3;
   logic                       raw3_below;
   logic                       cal_desc;
   logic [DIVISOR_W-1:0]       den_mag;
   logic [DIV_W-1:0]           num_mag;
   logic signed [SUM_W-1:0]    q_ext, base, temp_sum, offset_sum;
   logic                       le01, le02, le12, pick0, pick1;

   ctm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_comb begin
      unique case (csr_index)
         CSR_VREF_CAL:    csr_prdata = CSR_DATA_W'(vref_cal_ff);
         CSR_CAL_LOW:     csr_prdata = CSR_DATA_W'(cal_low_ff);
         CSR_CAL_HIGH:    csr_prdata = CSR_DATA_W'(cal_high_ff);
         CSR_TEMP_OFFSET: csr_prdata = CSR_DATA_W'($unsigned(offset_ff));
         default:         csr_prdata = '0;
      endcase
   end

   always_comb begin
      vref_cal_in = vref_cal_ff;
      cal_low_in  = cal_low_ff;
      cal_high_in = cal_high_ff;
      offset_in   = offset_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_VREF_CAL:    vref_cal_in = csr_pwdata[CAL_W-1:0];
            CSR_CAL_LOW:     cal_low_in  = csr_pwdata[CAL_W-1:0];
            CSR_CAL_HIGH:    cal_high_in = csr_pwdata[CAL_W-1:0];
            CSR_TEMP_OFFSET: offset_in   = $signed(csr_pwdata[OFFSET_W-1:0]);
            default:         offset_in   = offset_ff;
         endcase
      end
   end

   // Datapath pieces shared by the states below.
   assign vref_scaled = MV_W'(vref_cal_ff) * MV_W'(VREF_CAL_MV);
   assign digit_prod  = {2'b00, vdda_ff} * (MV_W+2)'(sensor_ff[RAW_W-1:RAW_W-2]);
   assign mul_sum     = {acc_ff[DIV_W-3:0], 2'b00} + DIV_W'(digit_prod);
   assign raw3        = div_rsp.quotient[RAW3_W-1:0];
   assign raw3_below  = raw3 < RAW3_W'(cal_low_ff);
   assign cal_desc    = cal_high_ff < cal_low_ff;
   assign den_mag     = cal_desc ? (cal_low_ff - cal_high_ff) : (cal_high_ff - cal_low_ff);
   assign num_mag     = DIV_W'(mag_ff) * DIV_W'(TEMP_SPAN);
   assign q_ext       = $signed({2'b00, div_rsp.quotient});
   assign base        = SUM_W'(TEMP_BASE);
   assign temp_sum    = neg_ff ? (base - q_ext) : (base + q_ext);
   assign offset_sum  = SUM_W'(med_t_ff) + SUM_W'(offset_ff);

   // Stable order: an earlier measurement precedes a later one on equal temperature.
   assign le01  = held_t_ff[0] <= held_t_ff[1];
   assign le02  = held_t_ff[0] <= t_ff;
   assign le12  = held_t_ff[1] <= t_ff;
   assign pick0 = le01 ^ le02;
   assign pick1 = le01 ^ ~le12;

   assign req_fire     = req_ch.valid && req_ready;
   assign req_ch.ready = req_ready;

   always_comb begin
      state_in       = state_ff;
      group_count_in = group_count_ff;
      status_in      = status_ff;
      sensor_in      = sensor_ff;
      mul_count_in   = mul_count_ff;
      acc_in         = acc_ff;
      vdda_in        = vdda_ff;
      mag_in         = mag_ff;
      neg_in         = neg_ff;
      t_in           = t_ff;
      med_t_in       = med_t_ff;
      med_v_in       = med_v_ff;
      held_t_in      = held_t_ff;
      held_v_in      = held_v_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_temp_in    = rsp_temp_ff;
      rsp_supply_in  = rsp_supply_ff;
      rsp_status_in  = rsp_status_ff;
      div_req        = '0;
      req_ready      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_ch.valid) begin
               sensor_in    = req_ch.raw_sensor;
               mul_count_in = '0;
               if (req_ch.vref_code == '0) begin
                  status_in      = STATUS_ZERO_REF;
                  group_count_in = '0;
                  state_in       = ST_EMIT;
               end else if (cal_high_ff == cal_low_ff) begin
                  status_in      = STATUS_EQUAL_CAL;
                  group_count_in = '0;
                  state_in       = ST_EMIT;
               end else begin
                  status_in        = STATUS_OK;
                  div_req.start    = 1'b1;
                  div_req.dividend = DIV_W'(vref_scaled);
                  div_req.divisor  = req_ch.vref_code;
                  state_in         = ST_DIV_VDDA;
               end
            end
         end
         ST_DIV_VDDA: begin
            if (div_rsp.done) begin
               vdda_in  = div_rsp.quotient[MV_W-1:0];
               acc_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            acc_in       = mul_sum;
            sensor_in    = {sensor_ff[RAW_W-3:0], 2'b00};
            mul_count_in = mul_count_ff + 1'b1;
            if (mul_count_ff == MUL_CNT_W'(MUL_DIGITS - 1)) begin
               div_req.start    = 1'b1;
               div_req.dividend = mul_sum;
               div_req.divisor  = DIVISOR_W'(SENSOR_CAL_MV);
               state_in         = ST_DIV_RAW3;
            end
         end
         ST_DIV_RAW3: begin
            if (div_rsp.done) begin
               mag_in   = raw3_below ? (RAW3_W'(cal_low_ff) - raw3) : (raw3 - RAW3_W'(cal_low_ff));
               neg_in   = raw3_below ^ cal_desc;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            div_req.start    = 1'b1;
            div_req.dividend = num_mag;
            div_req.divisor  = den_mag;
            state_in         = ST_DIV_TEMP;
         end
         ST_DIV_TEMP: begin
            if (div_rsp.done) begin
               t_in     = sat_temp(temp_sum);
               state_in = ST_TEMP;
            end
         end
         ST_TEMP: begin
            if (group_count_ff == 2'd2) begin
               state_in = ST_MEDIAN;
            end else begin
               held_t_in[group_count_ff[0]] = t_ff;
               held_v_in[group_count_ff[0]] = vdda_ff;
               group_count_in               = group_count_ff + 1'b1;
               state_in                     = ST_IDLE;
            end
         end
         ST_MEDIAN: begin
            if (pick0) begin
               med_t_in = held_t_ff[0];
               med_v_in = held_v_ff[0];
            end else if (pick1) begin
               med_t_in = held_t_ff[1];
               med_v_in = held_v_ff[1];
            end else begin
               med_t_in = t_ff;
               med_v_in = vdda_ff;
            end
            group_count_in = '0;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               if (status_ff == STATUS_OK) begin
                  rsp_temp_in   = sat_temp(offset_sum);
                  rsp_supply_in = med_v_ff;
               end else begin
                  rsp_temp_in   = '0;
                  rsp_supply_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vref_cal_ff    <= CAL_W'(VREF_CAL_RESET);
         cal_low_ff     <= CAL_W'(CAL_LOW_RESET);
         cal_high_ff    <= CAL_W'(CAL_HIGH_RESET);
         offset_ff      <= OFFSET_W'(TEMP_OFFSET_RESET);
         group_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         mul_count_ff   <= '0;
      end else begin
         vref_cal_ff    <= vref_cal_in;
         cal_low_ff     <= cal_low_in;
         cal_high_ff    <= cal_high_in;
         offset_ff      <= offset_in;
         group_count_ff <= group_count_in;
         rsp_valid_ff   <= rsp_valid_in;
         mul_count_ff   <= mul_count_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      sensor_ff     <= sensor_in;
      acc_ff        <= acc_in;
      vdda_ff       <= vdda_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      t_ff          <= t_in;
      med_t_ff      <= med_t_in;
      med_v_ff      <= med_v_in;
      held_t_ff     <= held_t_in;
      held_v_ff     <= held_v_in;
      rsp_temp_ff   <= rsp_temp_in;
      rsp_supply_ff <= rsp_supply_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.temp_tenths = rsp_temp_ff;
   assign rsp_ch.supply_mv   = rsp_supply_ff;
   assign rsp_ch.status      = rsp_status_ff;

   `CTM_ASSERT(group_count_bound, group_count_ff != 2'd3, "group count overflowed")
   `CTM_ASSERT_NEXT(zero_ref_restart, req_fire && req_ch.vref_code == '0, state_ff == ST_EMIT && group_count_ff == '0, "zero reference code did not restart the group")
   `CTM_ASSERT(error_zero_payload, rsp_valid_ff && rsp_status_ff != STATUS_OK |-> rsp_temp_ff == '0 && rsp_supply_ff == '0, "error beat carries data")
   `CTM_ASSERT(median_full_group, state_ff == ST_MEDIAN |-> group_count_ff == 2'd2, "median taken from a partial group")
   `CTM_ASSERT(idle_divider_free, state_ff == ST_IDLE |-> !div_rsp.busy, "divider busy while idle")

endmodule
